@@ rtl/core/fcr_pkg.sv @@
// Shared types, constants and the CRC-16/MODBUS byte update for the frame receiver.
`default_nettype none

package fcr_pkg;

   // frame markers
   localparam logic [7:0] HDR_FIRST  = 8'h5D;
   localparam logic [7:0] HDR_SECOND = 8'h7E;
   localparam logic [7:0] ACK_NONE   = 8'h50;
   localparam logic [7:0] ACK_WANT   = 8'h51;
   localparam logic [7:0] END_MARK   = 8'h5E;

   // CRC-16/MODBUS: reflected polynomial, no final xor
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // command codes
   localparam logic [7:0] CMD_LED   = 8'h26;
   localparam logic [7:0] CMD_IV_LO = 8'hA1;
   localparam logic [7:0] CMD_IV_HI = 8'hA5;

   // header, ack, length, two CRC bytes and end byte around the payload
   localparam logic [8:0] FRAME_EXTRA = 9'd7;

   // word kinds on the request channel
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_IDLE = 1'b1;

   // action codes
   typedef enum logic [1:0] {
      ACT_NONE     = 2'd0,
      ACT_LED_ACK  = 2'd1,
      ACT_IV_RESET = 2'd2
   } action_type;

   // hunt phases
   typedef enum logic [2:0] {
      PH_HDR1 = 3'd0,
      PH_HDR2 = 3'd1,
      PH_ACK  = 3'd2,
      PH_LEN  = 3'd3,
      PH_BODY = 3'd4
   } phase_type;

   // parser state
   typedef struct packed {
      phase_type   phase;
      logic [8:0]  bytes_taken;
      logic [8:0]  frame_total;
      logic [15:0] running_crc;
      logic [15:0] received_crc;
      logic [7:0]  held_command;
      logic [7:0]  held_first_data;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:           PH_HDR1,
      bytes_taken:     9'd0,
      frame_total:     9'd0,
      running_crc:     CRC_INIT,
      received_crc:    16'd0,
      held_command:    8'd0,
      held_first_data: 8'd0
   };

   // one result word
   typedef struct packed {
      logic       crc_good;
      logic [7:0] command;
      logic [7:0] first_data;
      logic [7:0] payload_length;
      action_type action;
   } result_type;

   // CRC update over one byte, LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/fcr_parser.sv @@
// Frame hunting state machine with running CRC; one word is handled per step.
`default_nettype none

module fcr_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic               word_type,
   input  wire logic [7:0]         word_byte,
   output fcr_pkg::result_type     result,
   output logic                    result_valid
);
   import fcr_pkg::*;

   state_type   state_ff;
   state_type   state_in;
   logic [9:0]  pos_ext;
   logic [9:0]  total_ext;
   logic        crc_match;
   action_type  act;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   // position compares, 10 bits so pos + 3 cannot wrap
   assign pos_ext   = {1'b0, state_ff.bytes_taken};
   assign total_ext = {1'b0, state_ff.frame_total};
   assign crc_match = (state_ff.received_crc == state_ff.running_crc);

   // action decode, only for a good CRC
   always_comb begin
      act = ACT_NONE;
      if (crc_match) begin
         if (state_ff.held_command == CMD_LED) begin
            act = ACT_LED_ACK;
         end else if (state_ff.held_command >= CMD_IV_LO &&
                      state_ff.held_command <= CMD_IV_HI) begin
            act = ACT_IV_RESET;
         end
      end
   end

   // result fields come straight from held state
   assign result.crc_good       = crc_match;
   assign result.command        = state_ff.held_command;
   assign result.first_data     = state_ff.held_first_data;
   assign result.payload_length = 8'(state_ff.frame_total - FRAME_EXTRA);
   assign result.action         = act;

   // next state
   always_comb begin
      state_in     = state_ff;
      result_valid = 1'b0;
      if (step) begin
         if (word_type == REQ_IDLE) begin
            // idle tick drops any partial frame
            state_in = STATE_RESET;
         end else begin
            unique case (state_ff.phase)
               PH_HDR2: begin
                  if (word_byte == HDR_SECOND) begin
                     state_in.running_crc = crc_byte(state_ff.running_crc, word_byte);
                     state_in.bytes_taken = 9'd2;
                     state_in.phase       = PH_ACK;
                  end
               end
               PH_ACK: begin
                  if (word_byte == ACK_NONE || word_byte == ACK_WANT) begin
                     state_in.running_crc = crc_byte(state_ff.running_crc, word_byte);
                     state_in.bytes_taken = 9'd3;
                     state_in.phase       = PH_LEN;
                  end
               end
               PH_LEN: begin
                  state_in.running_crc = crc_byte(state_ff.running_crc, word_byte);
                  state_in.frame_total = {1'b0, word_byte} + FRAME_EXTRA;
                  state_in.bytes_taken = 9'd4;
                  state_in.phase       = PH_BODY;
               end
               PH_BODY: begin
                  state_in.bytes_taken = state_ff.bytes_taken + 9'd1;
                  if (state_ff.bytes_taken == 9'd4) begin
                     state_in.held_command = word_byte;
                  end
                  if (state_ff.bytes_taken == 9'd5) begin
                     state_in.held_first_data = word_byte;
                  end
                  if (pos_ext + 10'd3 < total_ext) begin
                     // payload byte
                     state_in.running_crc = crc_byte(state_ff.running_crc, word_byte);
                  end else if (pos_ext + 10'd3 == total_ext) begin
                     state_in.received_crc[7:0] = word_byte;
                  end else if (pos_ext + 10'd2 == total_ext) begin
                     state_in.received_crc[15:8] = word_byte;
                  end else begin
                     // last position: report on a good end byte, restart either way
                     result_valid = (word_byte == END_MARK);
                     state_in     = STATE_RESET;
                  end
               end
               default: begin
                  // waiting for the first header byte; unused codes land here too
                  if (word_byte == HDR_FIRST) begin
                     state_in             = STATE_RESET;
                     state_in.running_crc = crc_byte(CRC_INIT, word_byte);
                     state_in.bytes_taken = 9'd1;
                     state_in.phase       = PH_HDR2;
                  end
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/framed_uart_command_receiver.sv @@
// Top level of the framed UART command receiver: input register, parser, result register.
//
// Request channel: one word per accepted transfer, either a received UART byte
// (req_type = 0, value on req_rx_byte) or an idle tick (req_type = 1) that
// drops any partial frame. A word is taken when req_valid is high and
// req_stall is low.
// Response channel: one word per complete frame whose end byte is 0x5E,
// carrying the CRC verdict, command, first data byte, length byte and action.
// Frames with a wrong end byte and all other bytes give no response.
// Throughput: one request word per cycle while rsp_stall does not hold a pending
// response. The CRC byte update and the frame bookkeeping fit between the input
// register and the result register. Path: a frame's end byte is loaded into the
// input register, then its response into the result register; rsp_stall can hold it between.
// Stall: while rsp_stall holds a pending response, the input register holds
// its word and req_stall rises only if that register is occupied; a response
// stays valid and unchanged until it is taken.
// Reset: synchronous, active high; clears the valid flags of both registers and returns the
// parser to hunting for the first header byte with the CRC at 0xFFFF.
`default_nettype none

module framed_uart_command_receiver (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_type,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_crc_good,
   output logic [7:0]      rsp_command,
   output logic [7:0]      rsp_first_data,
   output logic [7:0]      rsp_payload_length,
   output logic [1:0]      rsp_action
);
   import fcr_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic       in_type_ff;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       step;
   logic       req_take;
   result_type parse_result;
   logic       parse_valid;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;

   // pipeline moves when the result register is free or being emptied
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // input register
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff <= req_type;
         in_byte_ff <= req_rx_byte;
      end
   end

   fcr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .word_type    (in_type_ff),
      .word_byte    (in_byte_ff),
      .result       (parse_result),
      .result_valid (parse_valid)
   );

   // result register
   assign out_valid_in = advance ? (step && parse_valid) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && parse_valid) begin
         out_ff <= parse_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_crc_good       = out_ff.crc_good;
   assign rsp_command        = out_ff.command;
   assign rsp_first_data     = out_ff.first_data;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_action         = out_ff.action;

endmodule

`default_nettype wire

@@ rtl/core/fcr_checker.sv @@
// Port-level checks for the frame receiver, bound to the top level.
`default_nettype none

module fcr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_crc_good,
   input wire logic [7:0] rsp_command,
   input wire logic [7:0] rsp_first_data,
   input wire logic [7:0] rsp_payload_length,
   input wire logic [1:0] rsp_action
);
   import fcr_pkg::*;

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // an action is only requested for a good CRC
   a_action_needs_crc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action != ACT_NONE) |-> rsp_crc_good)
      else $error("action with bad CRC");

   // LED acknowledge only for its command
   a_led_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_LED_ACK) |-> rsp_command == CMD_LED)
      else $error("LED action on other command");

   // interval restore only for its command range
   a_iv_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_IV_RESET) |->
      (rsp_command >= CMD_IV_LO && rsp_command <= CMD_IV_HI))
      else $error("interval action on other command");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_crc_good) &&
      $stable(rsp_command) && $stable(rsp_first_data) &&
      $stable(rsp_payload_length) && $stable(rsp_action)))
      else $error("stalled response changed");

endmodule

bind framed_uart_command_receiver fcr_checker u_fcr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_crc_good       (rsp_crc_good),
   .rsp_command        (rsp_command),
   .rsp_first_data     (rsp_first_data),
   .rsp_payload_length (rsp_payload_length),
   .rsp_action         (rsp_action)
);

`default_nettype wire

@@ bench/framed_uart_command_receiver_test.sv @@
// Self-checking testbench for the framed UART command receiver: frames, noise, idle ticks, stalls.
module framed_uart_command_receiver_test;
   import fcr_pkg::*;

   localparam int WAIT_MAX    = 18;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 12;
   localparam int HOLD_CYCLES = 150;
   localparam int WORD_TARGET = 850;
   localparam int PRINT_LIMIT = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_type = REQ_BYTE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_crc_good;
   logic [7:0] rsp_command;
   logic [7:0] rsp_first_data;
   logic [7:0] rsp_payload_length;
   logic [1:0] rsp_action;

   // frame parser mirror
   phase_type  hunt;
   logic [8:0] taken_cnt;
   logic [8:0] total_len;
   logic [15:0] crc_acc;
   logic [15:0] crc_rcvd;
   logic [7:0] cmd_seen;
   logic [7:0] data_seen;
   result_type expected_frames[$];

   // payload bytes of the next frame to send
   logic [7:0] frame_body[$];

   int error_count = 0;
   int words_sent = 0;
   int send_wait_max = WAIT_MAX;
   int rcv_wait_max = WAIT_MAX;
   int holdoff_request = 0;
   int stall_left = 0;
   int holdoff_left = 0;
   int quiet_cycles = 0;

   framed_uart_command_receiver u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_crc_good       (rsp_crc_good),
      .rsp_command        (rsp_command),
      .rsp_first_data     (rsp_first_data),
      .rsp_payload_length (rsp_payload_length),
      .rsp_action         (rsp_action)
   );

   always #2 clock = ~clock;

   // bit-serial CRC-16/MODBUS, data fed LSB first
   function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ b[i];
         r = r >> 1;
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   function automatic int draw_wait(input int maxw);
      return (maxw == 0) ? 0 : $urandom_range(0, maxw);
   endfunction

   function automatic int pick_wait_max();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 3;
         default: return WAIT_MAX;
      endcase
   endfunction

   // command mix weighted toward the decoded codes and their neighbors
   function automatic logic [7:0] pick_command();
      case ($urandom_range(0, 9))
         0, 1, 2: return CMD_LED;
         3, 4, 5: return 8'($urandom_range(CMD_IV_LO, CMD_IV_HI));
         6: return CMD_IV_LO - 8'd1;
         7: return CMD_IV_HI + 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic report_error(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("%0t error: %s", $time, msg);
      end
      error_count++;
   endtask

   task automatic clear_parser();
      hunt = PH_HDR1;
      taken_cnt = 9'd0;
      total_len = 9'd0;
      crc_acc = CRC_INIT;
      crc_rcvd = 16'd0;
      cmd_seen = 8'd0;
      data_seen = 8'd0;
   endtask

   // advance the mirror by one accepted word; queue a frame report if one completes
   task automatic predict_word(input logic kind, input logic [7:0] b);
      int         pos;
      result_type r;
      if (kind == REQ_IDLE) begin
         clear_parser();
         return;
      end
      case (hunt)
         PH_HDR2: begin
            if (b == HDR_SECOND) begin
               crc_acc = crc16_update(crc_acc, b);
               taken_cnt = 9'd2;
               hunt = PH_ACK;
            end
         end
         PH_ACK: begin
            if (b == ACK_NONE || b == ACK_WANT) begin
               crc_acc = crc16_update(crc_acc, b);
               taken_cnt = 9'd3;
               hunt = PH_LEN;
            end
         end
         PH_LEN: begin
            crc_acc = crc16_update(crc_acc, b);
            total_len = {1'b0, b} + FRAME_EXTRA;
            taken_cnt = 9'd4;
            hunt = PH_BODY;
         end
         PH_BODY: begin
            pos = int'(taken_cnt);
            taken_cnt = taken_cnt + 9'd1;
            if (pos == 4) cmd_seen = b;
            if (pos == 5) data_seen = b;
            if (pos + 3 < int'(total_len)) begin
               crc_acc = crc16_update(crc_acc, b);
            end else if (pos + 3 == int'(total_len)) begin
               crc_rcvd[7:0] = b;
            end else if (pos + 2 == int'(total_len)) begin
               crc_rcvd[15:8] = b;
            end else if (b != END_MARK) begin
               clear_parser();
            end else begin
               r.crc_good = (crc_rcvd == crc_acc);
               r.command = cmd_seen;
               r.first_data = data_seen;
               r.payload_length = 8'(total_len - FRAME_EXTRA);
               r.action = ACT_NONE;
               if (r.crc_good) begin
                  if (cmd_seen == CMD_LED) begin
                     r.action = ACT_LED_ACK;
                  end else if (cmd_seen >= CMD_IV_LO && cmd_seen <= CMD_IV_HI) begin
                     r.action = ACT_IV_RESET;
                  end
               end
               expected_frames.push_back(r);
               clear_parser();
            end
         end
         default: begin
            if (b == HDR_FIRST) begin
               clear_parser();
               crc_acc = crc16_update(CRC_INIT, b);
               taken_cnt = 9'd1;
               hunt = PH_HDR2;
            end
         end
      endcase
   endtask

   // offer one word after a random gap and hold it until taken
   task automatic send_word(input logic kind, input logic [7:0] b);
      int gap;
      gap = draw_wait(send_wait_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(kind, b);
      words_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_word(REQ_BYTE, b);
   endtask

   task automatic send_idle();
      send_word(REQ_IDLE, 8'($urandom_range(0, 255)));
   endtask

   task automatic fill_body(input int n, input logic [7:0] cmd);
      frame_body = {};
      for (int i = 0; i < n; i++) begin
         frame_body.push_back((i == 0) ? cmd : 8'($urandom_range(0, 255)));
      end
   endtask

   // full frame around frame_body; optional stray bytes in the header phases
   task automatic send_frame(input logic [7:0] ack, input bit bad_crc,
                             input logic [7:0] end_byte, input bit header_noise);
      logic [15:0] c;
      logic [7:0]  noise;
      c = crc16_update(CRC_INIT, HDR_FIRST);
      send_byte(HDR_FIRST);
      if (header_noise) begin
         do noise = 8'($urandom_range(0, 255)); while (noise == HDR_SECOND);
         send_byte(noise);
      end
      send_byte(HDR_SECOND);
      c = crc16_update(c, HDR_SECOND);
      if (header_noise) begin
         do noise = 8'($urandom_range(0, 255)); while (noise == ACK_NONE || noise == ACK_WANT);
         send_byte(noise);
      end
      send_byte(ack);
      c = crc16_update(c, ack);
      send_byte(8'(frame_body.size()));
      c = crc16_update(c, 8'(frame_body.size()));
      foreach (frame_body[i]) begin
         send_byte(frame_body[i]);
         c = crc16_update(c, frame_body[i]);
      end
      if (bad_crc) begin
         c = c ^ (16'd1 << $urandom_range(0, 15));
      end
      send_byte(c[7:0]);
      send_byte(c[15:8]);
      send_byte(end_byte);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
   endtask

   // response side: compare against the oldest queued frame report
   task automatic check_response();
      result_type want;
      if (expected_frames.size() == 0) begin
         report_error($sformatf("unexpected response, command %02h", rsp_command));
         return;
      end
      want = expected_frames.pop_front();
      if (rsp_crc_good !== want.crc_good)
         report_error($sformatf("crc_good %b, want %b", rsp_crc_good, want.crc_good));
      if (rsp_command !== want.command)
         report_error($sformatf("command %02h, want %02h", rsp_command, want.command));
      if (rsp_first_data !== want.first_data)
         report_error($sformatf("first_data %02h, want %02h", rsp_first_data, want.first_data));
      if (rsp_payload_length !== want.payload_length)
         report_error($sformatf("payload_length %0d, want %0d",
                                rsp_payload_length, want.payload_length));
      if (rsp_action !== want.action)
         report_error($sformatf("action %0d, want %0d", rsp_action, want.action));
   endtask

   // receiver: random stall per word, plus an optional long hold-off
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         check_response();
         stall_left = draw_wait(rcv_wait_max);
      end
      if (holdoff_request > 0) begin
         holdoff_left = holdoff_request;
         holdoff_request = 0;
      end
      rsp_stall <= (stall_left > 0) || (holdoff_left > 0);
      if (stall_left > 0) stall_left--;
      if (holdoff_left > 0) holdoff_left--;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("framed_uart_command_receiver_test: errors");
         $finish;
      end
   end

   // idle tick and noise in the first header phase, then an empty-payload frame with stray header bytes
   task automatic test_header_hunt();
      send_idle();
      send_byte(8'h00);
      send_byte(8'hFF);
      fill_body(0, 8'h00);
      send_frame(ACK_WANT, 1'b0, END_MARK, 1'b1);
   endtask

   task automatic test_led_frame();
      frame_body = {CMD_LED, 8'h01};
      send_frame(ACK_NONE, 1'b0, END_MARK, 1'b0);
   endtask

   // wrong end byte drops the frame without a report
   task automatic test_wrong_end();
      fill_body(0, 8'h00);
      send_frame(ACK_WANT, 1'b0, 8'h00, 1'b0);
   endtask

   // idle tick in the middle of a header
   task automatic test_idle_drop();
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_idle();
   endtask

   // receiver holds off while the sender streams frames back to back
   task automatic test_backpressure();
      send_wait_max = 0;
      holdoff_request = HOLD_CYCLES;
      repeat (6) begin
         fill_body($urandom_range(0, 2), pick_command());
         send_frame($urandom_range(0, 1) ? ACK_WANT : ACK_NONE, 1'b0, END_MARK, 1'b0);
      end
      drain_responses();
      send_wait_max = WAIT_MAX;
   endtask

   task automatic test_max_length();
      fill_body(255, pick_command());
      send_frame(ACK_WANT, 1'b0, END_MARK, 1'b0);
   endtask

   // mostly well-formed frames, with noise, idle ticks and truncated frames mixed in
   task automatic test_random_traffic();
      int sel;
      int n;
      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 19) == 0) begin
            send_wait_max = pick_wait_max();
            rcv_wait_max = pick_wait_max();
         end
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            n = ($urandom_range(0, 24) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
            fill_body(n, pick_command());
            send_frame($urandom_range(0, 1) ? ACK_WANT : ACK_NONE,
                       $urandom_range(0, 4) == 0,
                       ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : END_MARK,
                       $urandom_range(0, 9) == 0);
         end else if (sel < 80) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end else if (sel < 88) begin
            send_idle();
         end else begin
            send_byte(HDR_FIRST);
            send_byte(HDR_SECOND);
            send_byte($urandom_range(0, 1) ? ACK_WANT : ACK_NONE);
            send_byte(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)));
            send_idle();
         end
      end
   endtask

   initial begin
      clear_parser();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_header_hunt();
      test_led_frame();
      test_wrong_end();
      test_idle_drop();
      test_backpressure();
      test_max_length();
      test_random_traffic();
      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("framed_uart_command_receiver_test: clean");
      end else begin
         $display("framed_uart_command_receiver_test: errors");
      end
      $finish;
   end

endmodule
